// ----- hdl/mvna_pkg.sv -----
// ----------------------------------------------------------------------------
// mvna_pkg
// shared codes, types and helpers for the mesh virtual to network address core
// ----------------------------------------------------------------------------
package mvna_pkg;

  // address field widths of the global and group regions
  localparam int GX_BITS = 6;
  localparam int GY_BITS = 5;
  localparam int WX_BITS = 6;
  localparam int WY_BITS = 6;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNMAPPED   = 3'd1;
  localparam logic [2:0] ST_GROUP_OOB  = 3'd2;
  localparam logic [2:0] ST_DRAM_RANGE = 3'd3;
  localparam logic [2:0] ST_NO_REGION  = 3'd4;

  // region codes
  localparam logic [1:0] RG_LOCAL  = 2'd0;
  localparam logic [1:0] RG_GROUP  = 2'd1;
  localparam logic [1:0] RG_GLOBAL = 2'd2;
  localparam logic [1:0] RG_DRAM   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_MESH_W    = 3'd2;
  localparam logic [2:0] CFG_MESH_H    = 3'd3;
  localparam logic [2:0] CFG_BASE_ROW  = 3'd4;
  localparam logic [2:0] CFG_NET_WIDTH = 3'd5;

  // tile offset decode result
  typedef struct packed {
    logic        hit;
    logic [30:0] epa;
    logic [30:0] sz;
  } dec_t;

  // ceil(log2(w)), saturating at 7
  function automatic logic [2:0] clog2_sat(input logic [6:0] w);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if ((8'd1 << i) < {1'b0, w}) begin
        n = 3'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/mvna_tile_dec.sv -----
// ----------------------------------------------------------------------------
// mvna_tile_dec
// tile offset decode: data memory window or one of the control registers
// ----------------------------------------------------------------------------
module mvna_tile_dec #(
  parameter int EPA_BITS          = 18,
  parameter int DMEM_BYTES        = 4096,
  parameter int DMEM_BASE         = 4096,
  parameter int CSR_FREEZE_ADDR   = 8192,
  parameter int CSR_ORIGIN_X_ADDR = 8196,
  parameter int CSR_ORIGIN_Y_ADDR = 8200
) (
  input  logic [EPA_BITS-1:0] tile_off,
  output mvna_pkg::dec_t      dec
);
  import mvna_pkg::*;

  logic [31:0] m;
  logic        in_dmem;
  logic        is_csr;

  assign m       = 32'(tile_off);
  assign in_dmem = m < 32'(DMEM_BYTES);
  assign is_csr  = (m == 32'(CSR_FREEZE_ADDR)) || (m == 32'(CSR_ORIGIN_X_ADDR)) ||
                   (m == 32'(CSR_ORIGIN_Y_ADDR));

  always_comb begin
    dec.hit = in_dmem || is_csr;
    if (in_dmem) begin
      dec.epa = 31'(m + 32'(DMEM_BASE));
      dec.sz  = 31'(32'(DMEM_BYTES) - m);
    end else begin
      dec.epa = 31'(m);
      dec.sz  = 31'd4;
    end
  end

endmodule

// ----- hdl/mesh_virtual_to_network_address_core.sv -----
// ----------------------------------------------------------------------------
// mesh_virtual_to_network_address_core
// translates a tile virtual address into a network destination and offset
// ----------------------------------------------------------------------------
// Each request carries a 32-bit virtual address and the issuing tile's mesh
// coordinates; the core answers with one result: status, region, destination
// x/y, endpoint offset and the bytes left in the segment. Regions are decoded
// in priority order DRAM, global, group, local. The core is a three-stage
// pipeline (region decode and coordinates, range checks and tile decode,
// segment size and error masking) with a valid bit per stage, so it takes one
// request every cycle while out_stall is low. A stalled output only backs up
// stages that hold data: empty stages keep accepting. Configuration registers
// are written through cfg_we and are read directly by the pipeline, so they
// are to be written only while it is empty; the core does not enforce this.
// ----------------------------------------------------------------------------
module mesh_virtual_to_network_address_core #(
  parameter int EPA_BITS          = 18,
  parameter int DMEM_BYTES        = 4096,
  parameter int DMEM_BASE         = 4096,
  parameter int CSR_FREEZE_ADDR   = 8192,
  parameter int CSR_ORIGIN_X_ADDR = 8196,
  parameter int CSR_ORIGIN_Y_ADDR = 8200
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_virt_addr,
  input  logic [5:0]  in_src_x,
  input  logic [5:0]  in_src_y,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_region,
  output logic [6:0]  out_dest_x,
  output logic [6:0]  out_dest_y,
  output logic [30:0] out_endpoint_offset,
  output logic [30:0] out_segment_bytes
);
  import mvna_pkg::*;

  localparam int GROUP_BIT  = EPA_BITS + GX_BITS + GY_BITS;
  localparam int GLOBAL_BIT = EPA_BITS + WX_BITS + WY_BITS;
  localparam int DRAM_BIT   = GLOBAL_BIT + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [5:0] origin_x_r, origin_y_r, base_row_r;
  logic [6:0] mesh_w_r, mesh_h_r;
  logic [4:0] net_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= 6'd0;
      origin_y_r  <= 6'd2;
      mesh_w_r    <= 7'd4;
      mesh_h_r    <= 7'd4;
      base_row_r  <= 6'd2;
      net_width_r <= 5'd28;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:  origin_x_r  <= cfg_data[5:0];
        CFG_ORIGIN_Y:  origin_y_r  <= cfg_data[5:0];
        CFG_MESH_W:    mesh_w_r    <= cfg_data;
        CFG_MESH_H:    mesh_h_r    <= cfg_data;
        CFG_BASE_ROW:  base_row_r  <= cfg_data[5:0];
        CFG_NET_WIDTH: net_width_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // derived DRAM geometry; the user must keep it static while requests are in flight, the core does not enforce this
  logic [2:0]  dram_xl;
  logic [4:0]  dram_shift;
  logic [5:0]  abits_raw;
  logic [4:0]  abits;
  logic [30:0] dram_maxsz;

  assign dram_xl    = clog2_sat(mesh_w_r);
  assign dram_shift = 5'(DRAM_BIT) - {2'b0, dram_xl};
  assign abits_raw  = {1'b0, net_width_r} + 6'd1;
  assign abits      = (abits_raw > 6'd30) ? 5'd30 : abits_raw[4:0];
  assign dram_maxsz = 31'd1 << abits;

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage moves when the next one is empty or moving
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: region decode and destination coordinates
  // --------------------------------------------------------------------------
  logic [31:0] va1_r;
  logic [1:0]  region1_r, region1_nxt;
  logic        none1_r, none1_nxt;
  logic [6:0]  x1_r, x1_nxt;
  logic [6:0]  y1_r, y1_nxt;
  logic [31:0] va_dram_sh;
  logic [31:0] xl_mask;

  assign va_dram_sh = in_virt_addr >> dram_shift;
  assign xl_mask    = (32'd1 << dram_xl) - 32'd1;

  always_comb begin
    none1_nxt   = 1'b0;
    region1_nxt = RG_LOCAL;
    x1_nxt      = {1'b0, in_src_x};
    y1_nxt      = {1'b0, in_src_y};
    if (in_virt_addr[DRAM_BIT]) begin
      region1_nxt = RG_DRAM;
      x1_nxt      = 7'(va_dram_sh & xl_mask);
      y1_nxt      = mesh_h_r + {1'b0, base_row_r};
    end else if (in_virt_addr[GLOBAL_BIT]) begin
      region1_nxt = RG_GLOBAL;
      x1_nxt      = {1'b0, in_virt_addr[EPA_BITS +: WX_BITS]};
      y1_nxt      = {1'b0, in_virt_addr[EPA_BITS + WX_BITS +: WY_BITS]};
    end else if (in_virt_addr[GROUP_BIT]) begin
      region1_nxt = RG_GROUP;
      x1_nxt      = {1'b0, in_virt_addr[EPA_BITS +: GX_BITS]} + {1'b0, origin_x_r};
      y1_nxt      = {2'b0, in_virt_addr[EPA_BITS + GX_BITS +: GY_BITS]} +
                    {1'b0, origin_y_r};
    end else if (in_virt_addr[31:EPA_BITS] != '0) begin
      // address bits above the tile window with no region bit set
      none1_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      va1_r     <= in_virt_addr;
      region1_r <= region1_nxt;
      none1_r   <= none1_nxt;
      x1_r      <= x1_nxt;
      y1_r      <= y1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: tile decode, group bounds, DRAM offset and no-region checks
  // --------------------------------------------------------------------------
  dec_t        tdec;
  logic [30:0] dram_epa;
  logic [2:0]  status2_r, status2_nxt;
  logic [1:0]  region2_r;
  logic [6:0]  x2_r, y2_r;
  logic [30:0] epa2_r, epa2_nxt;
  logic [30:0] sz2_r, sz2_nxt;
  logic [2:0]  tile_st;

  mvna_tile_dec #(
    .EPA_BITS          (EPA_BITS),
    .DMEM_BYTES        (DMEM_BYTES),
    .DMEM_BASE         (DMEM_BASE),
    .CSR_FREEZE_ADDR   (CSR_FREEZE_ADDR),
    .CSR_ORIGIN_X_ADDR (CSR_ORIGIN_X_ADDR),
    .CSR_ORIGIN_Y_ADDR (CSR_ORIGIN_Y_ADDR)
  ) u_tile_dec (
    .tile_off (va1_r[EPA_BITS-1:0]),
    .dec      (tdec)
  );

  assign dram_epa = 31'(va1_r & ((32'd1 << dram_shift) - 32'd1));
  assign tile_st  = tdec.hit ? ST_OK : ST_UNMAPPED;

  always_comb begin
    epa2_nxt    = tdec.epa;
    sz2_nxt     = tdec.sz;
    status2_nxt = tile_st;
    case (region1_r)
      RG_DRAM: begin
        // size is finished in stage 3 as maxsz minus offset
        epa2_nxt    = dram_epa;
        sz2_nxt     = dram_maxsz;
        status2_nxt = (dram_epa >= dram_maxsz) ? ST_DRAM_RANGE : ST_OK;
      end
      RG_GROUP: begin
        if (x1_r >= mesh_w_r || y1_r >= mesh_h_r) begin
          status2_nxt = ST_GROUP_OOB;
        end
      end
      RG_LOCAL: begin
        if (none1_r) begin
          status2_nxt = ST_NO_REGION;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      status2_r <= status2_nxt;
      region2_r <= region1_r;
      x2_r      <= x1_r;
      y2_r      <= y1_r;
      epa2_r    <= epa2_nxt;
      sz2_r     <= sz2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: DRAM segment size, zero everything but status and region on error
  // --------------------------------------------------------------------------
  logic        ok2;
  logic [30:0] sz3_calc;
  logic [2:0]  status3_r;
  logic [1:0]  region3_r;
  logic [6:0]  x3_r, x3_nxt;
  logic [6:0]  y3_r, y3_nxt;
  logic [30:0] epa3_r, epa3_nxt;
  logic [30:0] sz3_r, sz3_nxt;

  assign ok2      = status2_r == ST_OK;
  assign sz3_calc = (region2_r == RG_DRAM) ? (sz2_r - epa2_r) : sz2_r;
  assign x3_nxt   = ok2 ? x2_r : 7'd0;
  assign y3_nxt   = ok2 ? y2_r : 7'd0;
  assign epa3_nxt = ok2 ? epa2_r : 31'd0;
  assign sz3_nxt  = ok2 ? sz3_calc : 31'd0;

  always_ff @(posedge clk) begin
    if (en3) begin
      status3_r <= status2_r;
      region3_r <= region2_r;
      x3_r      <= x3_nxt;
      y3_r      <= y3_nxt;
      epa3_r    <= epa3_nxt;
      sz3_r     <= sz3_nxt;
    end
  end

  assign out_valid           = v3_r;
  assign out_status          = status3_r;
  assign out_region          = region3_r;
  assign out_dest_x          = x3_r;
  assign out_dest_y          = y3_r;
  assign out_endpoint_offset = epa3_r;
  assign out_segment_bytes   = sz3_r;

endmodule
